/* rtl/core/wri_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_pkg
// Shared types, constants and the cosine falloff table for the wave row
// intensity generator.
// ----------------------------------------------------------------------------
package wri_pkg;

  localparam int ROWS_DEF       = 16;
  localparam int WAVE_COUNT_DEF = 2;
  localparam int WAVE_MAX       = 2;
  localparam int POS_W          = 9;
  localparam int ROW_OUT_W      = 6;
  localparam int CH_W           = 8;
  localparam int COLOR_W        = 24;
  localparam int FACTOR_W       = 9;
  localparam int STEPS_PER_ROW  = 5;
  localparam int FALLOFF_REACH  = 15;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 32;
  localparam int CFG_IDX_W      = 2;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'h808080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_COLOR  = 2'd0,
    REG_SECOND_COLOR = 2'd1,
    REG_DIRECTIONS   = 2'd2
  } cfg_reg_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef pos_t [WAVE_MAX-1:0] pos_arr_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // round(256*cos(d*pi/30)), Q1.8 with 1.0 at d = 0
  function automatic logic [FACTOR_W-1:0] falloff_lookup(input logic [3:0] d);
    logic [FACTOR_W-1:0] f;
    unique case (d)
      4'd0:  f = 9'd256;
      4'd1:  f = 9'd255;
      4'd2:  f = 9'd250;
      4'd3:  f = 9'd243;
      4'd4:  f = 9'd234;
      4'd5:  f = 9'd222;
      4'd6:  f = 9'd207;
      4'd7:  f = 9'd190;
      4'd8:  f = 9'd171;
      4'd9:  f = 9'd150;
      4'd10: f = 9'd128;
      4'd11: f = 9'd104;
      4'd12: f = 9'd79;
      4'd13: f = 9'd53;
      4'd14: f = 9'd27;
      4'd15: f = 9'd0;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/wri_wave_pos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_wave_pos
// Wave center registers in fifths of a row, stepped once per frame with
// wrap at both ends of the column.
// ----------------------------------------------------------------------------
module wri_wave_pos
  import wri_pkg::*;
#(
  parameter int ROWS       = ROWS_DEF,
  parameter int WAVE_COUNT = WAVE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [WAVE_MAX-1:0] dir,
  output pos_arr_t            pos
);

  localparam pos_t POS_LAST  = POS_W'(STEPS_PER_ROW * ROWS - 1);
  localparam pos_t BACK_WRAP = POS_W'(STEPS_PER_ROW * (ROWS - 1));

  pos_arr_t pos_r;
  pos_arr_t pos_nxt;

  always_comb begin
    pos_nxt = pos_r;
    for (int w = 0; w < WAVE_MAX; w++) begin
      if (advance && (w < WAVE_COUNT)) begin
        if (dir[w]) begin
          pos_nxt[w] = (pos_r[w] == '0) ? BACK_WRAP : pos_r[w] - POS_W'(1);
        end else begin
          pos_nxt[w] = (pos_r[w] == POS_LAST) ? '0 : pos_r[w] + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

/* rtl/core/wri_shade.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_shade
// Shared shading unit: distance to one wave, falloff factor, and saturating
// accumulate of the scaled wave color on all three channels.
// ----------------------------------------------------------------------------
module wri_shade
  import wri_pkg::*;
(
  input  pos_t here,
  input  pos_t pos,
  input  rgb_t color,
  input  rgb_t acc,
  output rgb_t sum
);

  pos_t                dist_fifths;
  logic [FACTOR_W-1:0] factor;

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] c,
                                               input logic [FACTOR_W-1:0] f);
    logic [CH_W+FACTOR_W-1:0] prod;
    logic [CH_W+1:0]          s;
    prod = {{FACTOR_W{1'b0}}, c} * {{CH_W{1'b0}}, f};
    s    = {2'b00, a} + {1'b0, prod[CH_W+FACTOR_W-1:8]};
    return (s > (CH_W+2)'(255)) ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  always_comb begin
    dist_fifths = (here >= pos) ? here - pos : pos - here;
    factor = (dist_fifths <= POS_W'(FALLOFF_REACH)) ? falloff_lookup(dist_fifths[3:0]) : '0;
    sum.red   = sat_add(acc.red,   color.red,   factor);
    sum.green = sat_add(acc.green, color.green, factor);
    sum.blue  = sat_add(acc.blue,  color.blue,  factor);
  end

endmodule

/* rtl/core/wave_row_intensity_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_row_intensity_generator
// Moving two-wave row color generator with cosine falloff per row.
// ----------------------------------------------------------------------------
// A transaction with frame_tick set steps each wave one fifth of a row and
// then streams ROWS row colors, row 0 first, tlast on the last row. Input
// ready drops after the tick until the last row is registered for output,
// output stalls included: ST_MOVE steps the positions, then ST_SHADE takes
// each wave of each row in turn through the single shading unit. A
// transaction with frame_tick clear is taken while idle and produces
// nothing. Input is not ready while a frame is in work.
// ----------------------------------------------------------------------------
module wave_row_intensity_generator
  import wri_pkg::*;
#(
  parameter int ROWS       = ROWS_DEF,
  parameter int WAVE_COUNT = WAVE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] frame_tick, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [5:0] row_index, [13:6] red_level, [21:14] green_level,
  // [29:22] blue_level, [31:30] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last_row
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COLOR_W-1:0]    cfg_data
);

  localparam int                ROW_W    = $clog2(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SHADE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic                    wave_r, wave_nxt;
  pos_t                    here_r, here_nxt;
  rgb_t                    acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [COLOR_W-1:0]      first_color_r;
  logic [COLOR_W-1:0]      second_color_r;
  logic [WAVE_MAX-1:0]     dir_r;

  pos_arr_t                wave_pos;
  rgb_t                    acc_in;
  rgb_t                    color_sel;
  rgb_t                    shade_sum;
  logic                    wave_last;
  logic                    out_free;
  logic                    in_accept;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wave_last = (wave_r == 1'(WAVE_COUNT - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign acc_in    = (wave_r == 1'b0) ? rgb_t'('0) : acc_r;
  assign color_sel = wave_r ? rgb_t'(second_color_r) : rgb_t'(first_color_r);

  wri_wave_pos #(
    .ROWS       (ROWS),
    .WAVE_COUNT (WAVE_COUNT)
  ) u_wave_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (state_r == ST_MOVE),
    .dir     (dir_r),
    .pos     (wave_pos)
  );

  wri_shade u_shade (
    .here  (here_r),
    .pos   (wave_pos[wave_r]),
    .color (color_sel),
    .acc   (acc_in),
    .sum   (shade_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    wave_nxt      = wave_r;
    here_nxt      = here_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_tdata[0]) begin
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        state_nxt = ST_SHADE;
        row_nxt   = '0;
        wave_nxt  = 1'b0;
        here_nxt  = '0;
      end
      ST_SHADE: begin
        if (!wave_last) begin
          acc_nxt  = shade_sum;
          wave_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, shade_sum.blue, shade_sum.green, shade_sum.red,
                           ROW_OUT_W'(row_r)};
          out_last_nxt  = (row_r == ROW_LAST);
          wave_nxt      = 1'b0;
          row_nxt       = row_r + ROW_W'(1);
          here_nxt      = here_r + POS_W'(STEPS_PER_ROW);
          if (row_r == ROW_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      first_color_r  <= COLOR_RESET;
      second_color_r <= COLOR_RESET;
      dir_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FIRST_COLOR:  first_color_r  <= cfg_data;
          REG_SECOND_COLOR: second_color_r <= cfg_data;
          REG_DIRECTIONS:   dir_r          <= cfg_data[WAVE_MAX-1:0];
          default: ;
        endcase
      end
    end
    row_r      <= row_nxt;
    wave_r     <= wave_nxt;
    here_r     <= here_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_pos0_range: assert property (@(posedge clk) disable iff (!rst_n)
    wave_pos[0] < POS_W'(STEPS_PER_ROW * ROWS))
    else $error("wave 0 position out of range");

  a_pos1_range: assert property (@(posedge clk) disable iff (!rst_n)
    wave_pos[1] < POS_W'(STEPS_PER_ROW * ROWS))
    else $error("wave 1 position out of range");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[0]) |=> !in_tready)
    else $error("input ready during frame");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[ROW_OUT_W-1:0] == ROW_OUT_W'(ROWS - 1)))
    else $error("tlast on wrong row");
`endif

endmodule
